// ===== sv/cds_pkg.sv =====
// Shared types, constants and calendar helper functions for the date stepper.
`default_nettype none

package cds_pkg;

  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WDAY_W    = 3;
  localparam int CMD_W     = 2;
  localparam int AMT_W     = 11;
  localparam int STEP_W    = 12;   // signed remaining step count
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 14;
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 40;

  localparam logic [YEAR_W-1:0]  YEAR_MIN      = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
  localparam logic [YEAR_W-1:0]  HOME_YEAR_RST = 14'd2000;
  localparam logic [MONTH_W-1:0] MONTH_FIRST   = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_LAST    = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST     = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC  = 5'd31;

  typedef enum logic [CMD_W-1:0] {
    CMD_DAYS   = 2'd0,
    CMD_MONTHS = 2'd1,
    CMD_HOME   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOME_YEAR  = 2'd0,
    REG_HOME_MONTH = 2'd1,
    REG_HOME_DAY   = 2'd2
  } cfg_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_START = 4'd1,   // latch step count, clear flag
    OP_HOME  = 4'd2,   // load home date (day clamp follows)
    OP_DAY   = 4'd3,   // one month-sized piece of a day step
    OP_LDIV  = 4'd4,   // year / 100 for leap test
    OP_LSET  = 4'd5,   // leap flag from quotient and remainder
    OP_MDIV  = 4'd6,   // month index
    OP_MQ    = 4'd7,   // month index / 12
    OP_MSET  = 4'd8,   // new year and month
    OP_CLAMP = 4'd9,   // clamp day to month length
    OP_ZDIV  = 4'd10,  // Zeller year / 100
    OP_ZSUM  = 4'd11,  // Zeller sum
    OP_ZQ    = 4'd12,  // sum / 7
    OP_ZMOD  = 4'd13,  // first weekday of month
    OP_OUT   = 4'd14   // load result register
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic n_zero;      // no days left to move
    logic leap_stale;  // year changed, leap flag not yet recomputed
  } dp_status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end else if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = 5'd31;
    end
    return len;
  endfunction

  // floor(13 * (m' + 1) / 5), with Jan/Feb counted as months 13/14
  function automatic logic [5:0] zeller_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd36;
      4'd2:    t = 6'd39;
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // x mod 7 for x up to 63: quotient by reciprocal multiply, then remainder
  function automatic logic [WDAY_W-1:0] mod7(input logic [5:0] x);
    logic [11:0] p;
    logic [5:0]  r;
    p = {6'd0, x} * 12'd37;              // ~ x / 7 << 8
    r = x - ({2'd0, p[11:8]} * 6'd7);
    return r[WDAY_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cds_datapath.sv =====
// Date registers, home registers, step arithmetic and weekday datapath.
`default_nettype none

module cds_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cds_pkg::dp_cmd_t                  cmd,
  output cds_pkg::dp_status_t                    status,
  input  wire logic [cds_pkg::AMT_W-1:0]         amount,
  input  wire logic                              cfg_we,
  input  wire logic [cds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cds_pkg::CFG_DAT_W-1:0]     cfg_data,
  output logic      [cds_pkg::YEAR_W-1:0]        out_year,
  output logic      [cds_pkg::MONTH_W-1:0]       out_month,
  output logic      [cds_pkg::DAY_W-1:0]         out_day,
  output logic      [cds_pkg::WDAY_W-1:0]        weekday,
  output logic      [cds_pkg::DAY_W-1:0]         month_length,
  output logic      [cds_pkg::WDAY_W-1:0]        first_weekday,
  output logic                                   range_clamped
);

  // home date
  logic [cds_pkg::YEAR_W-1:0]  home_year;
  logic [cds_pkg::MONTH_W-1:0] home_month;
  logic [cds_pkg::DAY_W-1:0]   home_day;

  // current date
  logic [cds_pkg::YEAR_W-1:0]  year;
  logic [cds_pkg::MONTH_W-1:0] month;
  logic [cds_pkg::DAY_W-1:0]   day;
  logic                        leap;
  logic                        leap_stale;
  logic                        clamped;

  logic signed [cds_pkg::STEP_W-1:0] n;

  // month step
  logic [11:0] mi;
  logic [7:0]  mq;

  // divide by 100
  logic [cds_pkg::YEAR_W-1:0] dv_opnd;
  logic [6:0]                 dv_quot;

  // Zeller
  logic [9:0] zs;
  logic [6:0] zq;
  logic [cds_pkg::WDAY_W-1:0] fw;

  logic [cds_pkg::DAY_W-1:0]   lim;
  logic [cds_pkg::DAY_W-1:0]   prev_len;
  logic [cds_pkg::DAY_W-1:0]   to_next;
  logic signed [12:0]          day_sum;
  logic signed [cds_pkg::STEP_W-1:0] n_fwd;
  logic signed [cds_pkg::STEP_W-1:0] n_back;
  logic [12:0]                 m_idx;
  logic [23:0]                 mq_prod;
  logic signed [15:0]          m_year;
  logic [11:0]                 m_rem;
  logic [cds_pkg::YEAR_W-1:0]  zel_year;
  logic [cds_pkg::YEAR_W-1:0]  dv_src;
  logic [26:0]                 dv_prod;
  logic [cds_pkg::YEAR_W-1:0]  dv_rem;
  logic [6:0]                  dv_k;
  logic [9:0]                  zs_sum;
  logic [22:0]                 zq_prod;
  logic [9:0]                  z_rem;
  logic [2:0]                  z_h;
  logic [5:0]                  wd_sum;

  assign lim      = cds_pkg::month_len(month, leap);
  assign prev_len = cds_pkg::month_len(month - 4'd1, leap);
  assign to_next  = lim - day + 5'd1;
  assign day_sum  = $signed({8'd0, day}) + $signed({n[cds_pkg::STEP_W-1], n});
  assign n_fwd    = n - $signed({7'd0, to_next});
  assign n_back   = n + $signed({7'd0, day});

  // month index offset by 100 years keeps it positive
  assign m_idx   = {9'd0, month} + {n[cds_pkg::STEP_W-1], n} + 13'd1199;
  assign mq_prod = mi * 12'd2731;                  // ~ mi / 12 << 15
  assign m_year  = $signed({2'b00, year}) + $signed({8'd0, mq}) - 16'sd100;
  assign m_rem   = mi - ({4'd0, mq} * 12'd12);

  assign zel_year = (month < 4'd3) ? (year - 14'd1) : year;
  assign dv_src   = (cmd.op == cds_pkg::OP_ZDIV) ? zel_year : year;
  assign dv_prod  = dv_src * 13'd5243;             // ~ / 100 << 19
  assign dv_rem   = dv_opnd - ({7'd0, dv_quot} * 14'd100);
  assign dv_k     = dv_rem[6:0];

  assign zs_sum = 10'd1 + {4'd0, cds_pkg::zeller_term(month)} + {3'd0, dv_k}
                + {5'd0, dv_k[6:2]} + {5'd0, dv_quot[6:2]}
                + ({3'd0, dv_quot} * 10'd5);
  assign zq_prod = zs * 13'd4682;                  // ~ / 7 << 15
  assign z_rem   = zs - ({3'd0, zq} * 10'd7);
  assign z_h     = z_rem[2:0];

  assign wd_sum = {3'd0, fw} + {1'b0, day} - 6'd1;

  assign status = '{n_zero: (n == '0), leap_stale: leap_stale};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      home_year  <= cds_pkg::HOME_YEAR_RST;
      home_month <= cds_pkg::MONTH_FIRST;
      home_day   <= cds_pkg::DAY_FIRST;
    end else if (cfg_we) begin
      case (cds_pkg::cfg_reg_t'(cfg_index))
        cds_pkg::REG_HOME_YEAR:  home_year  <= cfg_data;
        cds_pkg::REG_HOME_MONTH: home_month <= cfg_data[cds_pkg::MONTH_W-1:0];
        cds_pkg::REG_HOME_DAY:   home_day   <= cfg_data[cds_pkg::DAY_W-1:0];
        default: ;
      endcase
    end
  end

  // date state
  always_ff @(posedge clk) begin
    if (rst) begin
      year       <= cds_pkg::HOME_YEAR_RST;
      month      <= cds_pkg::MONTH_FIRST;
      day        <= cds_pkg::DAY_FIRST;
      leap       <= 1'b1;
      leap_stale <= 1'b0;
    end else begin
      case (cmd.op)
        cds_pkg::OP_HOME: begin
          if (home_year == '0) begin
            year <= cds_pkg::YEAR_MIN;
          end else if (home_year > cds_pkg::YEAR_MAX) begin
            year <= cds_pkg::YEAR_MAX;
          end else begin
            year <= home_year;
          end
          if (home_month == '0) begin
            month <= cds_pkg::MONTH_FIRST;
          end else if (home_month > cds_pkg::MONTH_LAST) begin
            month <= cds_pkg::MONTH_LAST;
          end else begin
            month <= home_month;
          end
          day        <= (home_day == '0) ? cds_pkg::DAY_FIRST : home_day;
          leap_stale <= 1'b1;
        end
        cds_pkg::OP_DAY: begin
          if (!n[cds_pkg::STEP_W-1]) begin
            if (day_sum <= $signed({8'd0, lim})) begin
              day <= day_sum[cds_pkg::DAY_W-1:0];
            end else begin
              if (month == cds_pkg::MONTH_LAST) begin
                if (year >= cds_pkg::YEAR_MAX) begin
                  year       <= cds_pkg::YEAR_MAX;
                  month      <= cds_pkg::MONTH_LAST;
                  day        <= cds_pkg::DAY_LAST_DEC;
                  leap       <= 1'b0;
                  leap_stale <= 1'b0;
                end else begin
                  day        <= cds_pkg::DAY_FIRST;
                  month      <= cds_pkg::MONTH_FIRST;
                  year       <= year + 14'd1;
                  leap_stale <= 1'b1;
                end
              end else begin
                day   <= cds_pkg::DAY_FIRST;
                month <= month + 4'd1;
              end
            end
          end else begin
            if (day_sum > 13'sd0) begin
              day <= day_sum[cds_pkg::DAY_W-1:0];
            end else if (month == cds_pkg::MONTH_FIRST) begin
              if (year <= cds_pkg::YEAR_MIN) begin
                year       <= cds_pkg::YEAR_MIN;
                month      <= cds_pkg::MONTH_FIRST;
                day        <= cds_pkg::DAY_FIRST;
                leap       <= 1'b0;
                leap_stale <= 1'b0;
              end else begin
                // December is 31 days whatever the year
                month      <= cds_pkg::MONTH_LAST;
                year       <= year - 14'd1;
                day        <= cds_pkg::DAY_LAST_DEC;
                leap_stale <= 1'b1;
              end
            end else begin
              month <= month - 4'd1;
              day   <= prev_len;
            end
          end
        end
        cds_pkg::OP_LSET: begin
          // divisible by 100: leap only when the century count is a multiple of 4
          leap       <= (dv_k != '0) ? (dv_opnd[1:0] == 2'd0) : (dv_quot[1:0] == 2'd0);
          leap_stale <= 1'b0;
        end
        cds_pkg::OP_MSET: begin
          if (m_year < 16'sd1) begin
            year       <= cds_pkg::YEAR_MIN;
            month      <= cds_pkg::MONTH_FIRST;
            day        <= cds_pkg::DAY_FIRST;
            leap       <= 1'b0;
            leap_stale <= 1'b0;
          end else if (m_year > 16'sd9999) begin
            year       <= cds_pkg::YEAR_MAX;
            month      <= cds_pkg::MONTH_LAST;
            day        <= cds_pkg::DAY_LAST_DEC;
            leap       <= 1'b0;
            leap_stale <= 1'b0;
          end else begin
            year       <= m_year[cds_pkg::YEAR_W-1:0];
            month      <= m_rem[cds_pkg::MONTH_W-1:0] + 4'd1;
            leap_stale <= 1'b1;
          end
        end
        cds_pkg::OP_CLAMP: begin
          if (day > lim) begin
            day <= lim;
          end
        end
        default: ;
      endcase
    end
  end

  // step count and range flag
  always_ff @(posedge clk) begin
    case (cmd.op)
      cds_pkg::OP_START: begin
        n       <= {amount[cds_pkg::AMT_W-1], amount};
        clamped <= 1'b0;
      end
      cds_pkg::OP_HOME: begin
        clamped <= (home_year == '0) || (home_year > cds_pkg::YEAR_MAX);
      end
      cds_pkg::OP_DAY: begin
        if (!n[cds_pkg::STEP_W-1]) begin
          if (day_sum <= $signed({8'd0, lim})) begin
            n <= '0;
          end else if (month == cds_pkg::MONTH_LAST && year >= cds_pkg::YEAR_MAX) begin
            n       <= '0;
            clamped <= 1'b1;
          end else begin
            n <= n_fwd;
          end
        end else begin
          if (day_sum > 13'sd0) begin
            n <= '0;
          end else if (month == cds_pkg::MONTH_FIRST && year <= cds_pkg::YEAR_MIN) begin
            n       <= '0;
            clamped <= 1'b1;
          end else begin
            n <= n_back;
          end
        end
      end
      cds_pkg::OP_MSET: begin
        clamped <= (m_year < 16'sd1) || (m_year > 16'sd9999);
      end
      default: ;
    endcase
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      cds_pkg::OP_MDIV: mi <= m_idx[11:0];
      cds_pkg::OP_MQ:   mq <= mq_prod[22:15];
      cds_pkg::OP_LDIV, cds_pkg::OP_ZDIV: begin
        dv_opnd <= dv_src;
        dv_quot <= dv_prod[25:19];
      end
      cds_pkg::OP_ZSUM: zs <= zs_sum;
      cds_pkg::OP_ZQ:   zq <= zq_prod[21:15];
      cds_pkg::OP_ZMOD: fw <= (z_h == 3'd0) ? 3'd6 : (z_h - 3'd1);  // Sunday is 0
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == cds_pkg::OP_OUT) begin
      out_year      <= year;
      out_month     <= month;
      out_day       <= day;
      weekday       <= cds_pkg::mod7(wd_sum);
      month_length  <= lim;
      first_weekday <= fw;
      range_clamped <= clamped;
    end
  end

endmodule

`default_nettype wire

// ===== sv/cds_ctrl.sv =====
// Controller state machine sequencing the date stepper datapath.
`default_nettype none

module cds_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire cds_pkg::cmd_t        s_cmd,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output cds_pkg::dp_cmd_t          dp_cmd,
  input  wire cds_pkg::dp_status_t  dp_status
);

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_DAY  = 13'b0000000000010,
    ST_LDIV = 13'b0000000000100,
    ST_LSET = 13'b0000000001000,
    ST_MDIV = 13'b0000000010000,
    ST_MQ   = 13'b0000000100000,
    ST_MSET = 13'b0000001000000,
    ST_FIX  = 13'b0000010000000,
    ST_ZDIV = 13'b0000100000000,
    ST_ZSUM = 13'b0001000000000,
    ST_ZQ   = 13'b0010000000000,
    ST_ZMOD = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   ret_day;       // leap update returns to day stepping
  logic   ret_day_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    ret_day_next = ret_day;
    dp_cmd.op    = cds_pkg::OP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_cmd)
            cds_pkg::CMD_DAYS: begin
              dp_cmd.op  = cds_pkg::OP_START;
              state_next = ST_DAY;
            end
            cds_pkg::CMD_MONTHS: begin
              dp_cmd.op  = cds_pkg::OP_START;
              state_next = ST_MDIV;
            end
            cds_pkg::CMD_HOME: begin
              dp_cmd.op  = cds_pkg::OP_HOME;
              state_next = ST_FIX;
            end
            default: begin
              dp_cmd.op  = cds_pkg::OP_START;
              state_next = ST_ZDIV;
            end
          endcase
        end
      end
      ST_DAY: begin
        if (dp_status.leap_stale) begin
          ret_day_next = 1'b1;
          state_next   = ST_LDIV;
        end else if (dp_status.n_zero) begin
          state_next = ST_ZDIV;
        end else begin
          dp_cmd.op = cds_pkg::OP_DAY;
        end
      end
      ST_LDIV: begin
        dp_cmd.op  = cds_pkg::OP_LDIV;
        state_next = ST_LSET;
      end
      ST_LSET: begin
        dp_cmd.op  = cds_pkg::OP_LSET;
        state_next = ret_day ? ST_DAY : ST_FIX;
      end
      ST_MDIV: begin
        dp_cmd.op  = cds_pkg::OP_MDIV;
        state_next = ST_MQ;
      end
      ST_MQ: begin
        dp_cmd.op  = cds_pkg::OP_MQ;
        state_next = ST_MSET;
      end
      ST_MSET: begin
        dp_cmd.op  = cds_pkg::OP_MSET;
        state_next = ST_FIX;
      end
      ST_FIX: begin
        if (dp_status.leap_stale) begin
          ret_day_next = 1'b0;
          state_next   = ST_LDIV;
        end else begin
          dp_cmd.op  = cds_pkg::OP_CLAMP;
          state_next = ST_ZDIV;
        end
      end
      ST_ZDIV: begin
        dp_cmd.op  = cds_pkg::OP_ZDIV;
        state_next = ST_ZSUM;
      end
      ST_ZSUM: begin
        dp_cmd.op  = cds_pkg::OP_ZSUM;
        state_next = ST_ZQ;
      end
      ST_ZQ: begin
        dp_cmd.op  = cds_pkg::OP_ZQ;
        state_next = ST_ZMOD;
      end
      ST_ZMOD: begin
        dp_cmd.op  = cds_pkg::OP_ZMOD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          dp_cmd.op  = cds_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ret_day  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      ret_day <= ret_day_next;
      if (dp_cmd.op == cds_pkg::OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/calendar_date_stepper_unit.sv =====
// Top level of the calendar date stepper: ports, packing and checks.
//
// Keeps one Gregorian date (reset 2000-01-01) and answers every input beat
// with exactly one result beat.
// Input stream: s_tuser carries the command (move by days, move by months,
// load home date, no-op), s_tdata the signed step amount.
// Output stream: m_tdata carries the date, its weekday, the month length
// and the weekday of the month's first day; m_tuser flags a result that
// saturated at year 1 or 9999.
// Config channel: cfg_index selects home year, month or day; cfg_ready is
// always high. Write only while no command is in flight.
// After accept, a no-op goes straight to the weekday steps; a month step
// first forms the month index, its quotient by 12 and the new year and
// month; a home load or month step then refreshes the leap flag where
// needed and clamps the day. The day loop walks one month per cycle,
// pausing for a leap update at each year crossing; weekdays come from a
// short Zeller pipeline. s_tready is high only while idle, so a new command
// waits until the last one has loaded its result, which sits in the output
// register. A stalled receiver holds back only the next command's final load.
// Reset: synchronous; home date and current date return to 2000-01-01.
`default_nettype none

module calendar_date_stepper_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [cds_pkg::S_TDATA_W-1:0]      s_tdata,   // [10:0] amount
  input  wire logic [cds_pkg::CMD_W-1:0]          s_tuser,   // [1:0] cmd
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // [13:0] out_year, [17:14] out_month, [22:18] out_day, [25:23] weekday,
  // [30:26] month_length, [33:31] first_weekday, [39:34] zero
  output logic      [cds_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                    m_tuser,   // [0] range_clamped
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cds_pkg::CFG_DAT_W-1:0]      cfg_data
);

  cds_pkg::dp_cmd_t    dp_cmd;
  cds_pkg::dp_status_t dp_status;

  logic [cds_pkg::YEAR_W-1:0]  out_year;
  logic [cds_pkg::MONTH_W-1:0] out_month;
  logic [cds_pkg::DAY_W-1:0]   out_day;
  logic [cds_pkg::WDAY_W-1:0]  weekday;
  logic [cds_pkg::DAY_W-1:0]   month_length;
  logic [cds_pkg::WDAY_W-1:0]  first_weekday;
  logic                        range_clamped;

  assign cfg_ready = 1'b1;

  cds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_cmd     (cds_pkg::cmd_t'(s_tuser)),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  cds_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (dp_cmd),
    .status        (dp_status),
    .amount        (s_tdata[cds_pkg::AMT_W-1:0]),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .weekday       (weekday),
    .month_length  (month_length),
    .first_weekday (first_weekday),
    .range_clamped (range_clamped)
  );

  assign m_tdata = {6'd0, first_weekday, month_length, weekday,
                    out_day, out_month, out_year};
  assign m_tuser = range_clamped;

  // one command in flight: accepting a beat closes the input
  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a command is in flight");

  // every reported date is a real calendar date
  a_valid_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day != 5'd0 &&
                  out_day <= month_length && out_year >= 14'd1 &&
                  out_year <= 14'd9999))
    else $error("result date out of range");

  // month length agrees with the month
  a_month_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_month == 4'd2) ? (month_length == 5'd28 || month_length == 5'd29)
                                      : (month_length == 5'd30 || month_length == 5'd31)))
    else $error("month length inconsistent with month");

  // a saturated result sits at one end of the year range
  a_clamp_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (out_year == 14'd1 || out_year == 14'd9999))
    else $error("range flag set away from the year limits");

endmodule

`default_nettype wire

// ===== tb/sv/tb_calendar_date_stepper_unit.sv =====
// Self-checking testbench for calendar_date_stepper_unit, with a built-in date predictor.

module tb_calendar_date_stepper_unit;
  import cds_pkg::*;

  localparam int FIRST_YEAR   = YEAR_MIN;
  localparam int LAST_YEAR    = YEAR_MAX;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;

  // One result as the block reports it
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
    logic [DAY_W-1:0]   mlen;
    logic [WDAY_W-1:0]  first_wday;
    logic               clamped;
  } date_report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;   // [10:0] amount
  logic [CMD_W-1:0]     s_tuser  = CMD_NOP; // [1:0] cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HOME_YEAR;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;

  // Predictor copy of the home registers and of the current date
  logic [YEAR_W-1:0]  home_year  = HOME_YEAR_RST;
  logic [MONTH_W-1:0] home_month = MONTH_FIRST;
  logic [DAY_W-1:0]   home_day   = DAY_FIRST;
  logic [YEAR_W-1:0]  cur_year   = HOME_YEAR_RST;
  logic [MONTH_W-1:0] cur_month  = MONTH_FIRST;
  logic [DAY_W-1:0]   cur_day    = DAY_FIRST;

  date_report_t expected_reports[$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;   // chance per cycle that the sender holds off
  int           recv_stall_pct = 0;   // chance per cycle that the receiver stalls
  int           cycle_count    = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  calendar_date_stepper_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Calendar arithmetic
  // ---------------------------------------------------------------------
  function automatic bit is_leap(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int y, input int m);
    int n;
    case (m)
      4, 6, 9, 11: n = 30;
      2:           n = is_leap(y) ? 29 : 28;
      default:     n = 31;
    endcase
    return n;
  endfunction

  // Zeller's congruence; h counts from Saturday, shifted so Sunday is 0
  function automatic logic [WDAY_W-1:0] zeller_weekday(input int y, input int m, input int d);
    int k, j, h;
    if (m < 3) begin
      m = m + 12;
      y = y - 1;
    end
    k = y % 100;
    j = y / 100;
    h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
    return WDAY_W'((h + 6) % 7);
  endfunction

  // Applies one command to the predicted date and returns the report
  function automatic date_report_t advance_date(input cmd_t op, input logic [AMT_W-1:0] amt);
    int           y, m, d, n, lim, idx, ny;
    bit           sat;
    date_report_t rep;
    y   = cur_year;
    m   = cur_month;
    d   = cur_day;
    n   = $signed(amt);
    sat = 1'b0;
    case (op)
      CMD_DAYS: begin
        // walk forward a month at a time
        while (n > 0) begin
          lim = month_days(y, m);
          if (d + n <= lim) begin
            d = d + n;
            n = 0;
          end else begin
            n = n - (lim - d + 1);
            d = 1;
            if (m == 12) begin
              if (y >= LAST_YEAR) begin
                y = LAST_YEAR; m = 12; d = 31; sat = 1'b1; n = 0;
              end else begin
                m = 1;
                y = y + 1;
              end
            end else begin
              m = m + 1;
            end
          end
        end
        // walk backward, landing on the last day of the previous month
        while (n < 0) begin
          if (d + n > 0) begin
            d = d + n;
            n = 0;
          end else begin
            n = n + d;
            if (m == 1) begin
              if (y <= FIRST_YEAR) begin
                y = FIRST_YEAR; m = 1; d = 1; sat = 1'b1; n = 0;
              end else begin
                m = 12;
                y = y - 1;
                d = month_days(y, m);
              end
            end else begin
              m = m - 1;
              d = month_days(y, m);
            end
          end
        end
      end
      CMD_MONTHS: begin
        // offset of 100 years keeps the month index positive
        idx = m - 1 + n + 1200;
        ny  = y + idx / 12 - 100;
        if (ny < FIRST_YEAR) begin
          y = FIRST_YEAR; m = 1; d = 1; sat = 1'b1;
        end else if (ny > LAST_YEAR) begin
          y = LAST_YEAR; m = 12; d = 31; sat = 1'b1;
        end else begin
          y = ny;
          m = idx % 12 + 1;
          lim = month_days(y, m);
          if (d > lim) d = lim;
        end
      end
      CMD_HOME: begin
        y = home_year;
        if (y < FIRST_YEAR) begin
          y = FIRST_YEAR;
          sat = 1'b1;
        end
        if (y > LAST_YEAR) begin
          y = LAST_YEAR;
          sat = 1'b1;
        end
        m = home_month;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        lim = month_days(y, m);
        d = home_day;
        if (d < 1) d = 1;
        if (d > lim) d = lim;
      end
      default: begin
        // unused command: date unchanged, no flag
      end
    endcase
    cur_year  = YEAR_W'(y);
    cur_month = MONTH_W'(m);
    cur_day   = DAY_W'(d);
    rep.year       = cur_year;
    rep.month      = cur_month;
    rep.day        = cur_day;
    rep.wday       = zeller_weekday(y, m, d);
    rep.mlen       = DAY_W'(month_days(y, m));
    rep.first_wday = zeller_weekday(y, m, 1);
    rep.clamped    = sat;
    return rep;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------
  // Sends one command beat. tvalid stays high on return so that a
  // following beat can go out back to back; wait_idle lowers it.
  task automatic send_cmd(input cmd_t op, input logic [AMT_W-1:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= S_TDATA_W'($urandom);   // junk while idle
      s_tuser  <= CMD_W'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-AMT_W){1'b0}}, amt};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_reports.push_back(advance_date(op, amt));
  endtask

  // Block is idle once every pending report has come back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_HOME_YEAR:  home_year  = val[YEAR_W-1:0];
      REG_HOME_MONTH: home_month = val[MONTH_W-1:0];
      REG_HOME_DAY:   home_day   = val[DAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_home(input logic [CFG_DAT_W-1:0] y, input logic [CFG_DAT_W-1:0] m,
                          input logic [CFG_DAT_W-1:0] d);
    wait_idle();
    write_reg(REG_HOME_YEAR, y);
    write_reg(REG_HOME_MONTH, m);
    write_reg(REG_HOME_DAY, d);
    cfg_valid <= 1'b0;
  endtask

  // Small steps and full-range values in equal shares, plus the extremes
  function automatic logic [AMT_W-1:0] pick_amount();
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = $urandom_range(80) - 40;
    end else if (sel < 80) begin
      v = $urandom_range(2047);
    end else begin
      case ($urandom_range(3))
        0:       v = 1023;
        1:       v = -1024;
        2:       v = -1023;
        default: v = 0;
      endcase
    end
    return v[AMT_W-1:0];
  endfunction

  function automatic cmd_t pick_cmd();
    int sel;
    cmd_t op;
    sel = $urandom_range(99);
    if (sel < 45)      op = CMD_DAYS;
    else if (sel < 75) op = CMD_MONTHS;
    else if (sel < 90) op = CMD_HOME;
    else               op = CMD_NOP;
    return op;
  endfunction

  // Home dates lean toward the year bounds so saturation gets exercised
  task automatic set_random_home();
    logic [CFG_DAT_W-1:0] y, m, d;
    case ($urandom_range(9))
      0:       y = CFG_DAT_W'($urandom_range(60));            // includes year 0
      1:       y = CFG_DAT_W'(9940 + $urandom_range(59));     // up to 9999
      2:       y = CFG_DAT_W'(10000 + $urandom_range(6383));  // above range
      default: y = CFG_DAT_W'(1 + $urandom_range(9998));
    endcase
    m = CFG_DAT_W'(($urandom_range(7) == 0) ? $urandom_range(15) : 1 + $urandom_range(11));
    d = CFG_DAT_W'($urandom_range(31));
    set_home(y, m, d);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // From the reset date: unused command, amount extremes, zero steps
  task automatic test_reset_state();
    send_cmd(CMD_NOP, '0);
    send_cmd(CMD_DAYS, 11'h3FF);
    send_cmd(CMD_DAYS, 11'h400);
    send_cmd(CMD_MONTHS, 11'h3FF);
    send_cmd(CMD_MONTHS, 11'h400);
    send_cmd(CMD_DAYS, '0);
    send_cmd(CMD_MONTHS, '0);
  endtask

  // Day and month steps past year 9999 and below year 1
  task automatic test_saturation();
    set_home(14'd9999, 14'd12, 14'd20);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_DAYS, 11'h3FF);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_MONTHS, 11'd1);
    set_home(14'd0, 14'd0, 14'd0);     // all three out of range low
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_DAYS, 11'h7FF);       // -1
    send_cmd(CMD_MONTHS, 11'h7FF);
  endtask

  // Home year and month above range, then a day beyond the month end
  task automatic test_home_clamping();
    set_home(14'h3FFF, 14'd15, 14'd31);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_NOP, 11'h2AA);        // flag must drop on a no-op
    set_home(14'd2000, 14'd2, 14'd31);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_DAYS, 11'd1);
  endtask

  // Century rule and the day clamp on a month step into February
  task automatic test_leap_months();
    set_home(14'd1900, 14'd2, 14'd29);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_MONTHS, 11'd12);
    set_home(14'd2024, 14'd1, 14'd31);
    send_cmd(CMD_HOME, '0);
    send_cmd(CMD_MONTHS, 11'd1);
  endtask

  // Random commands in chunks, each chunk from a fresh home date
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int chunks,
                                     input int per_chunk);
    wait_idle();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int c = 0; c < chunks; c++) begin
      set_random_home();
      send_cmd(CMD_HOME, pick_amount());
      for (int i = 1; i < per_chunk; i++) begin
        send_cmd(pick_cmd(), pick_amount());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Result check: each beat against the oldest pending report
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    date_report_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.year       = m_tdata[13:0];
      got.month      = m_tdata[17:14];
      got.day        = m_tdata[22:18];
      got.wday       = m_tdata[25:23];
      got.mlen       = m_tdata[30:26];
      got.first_wday = m_tdata[33:31];
      got.clamped    = m_tuser;
      if (expected_reports.size() == 0) begin
        $error("result beat with no pending report: %0d-%0d-%0d",
               got.year, got.month, got.day);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("out_year", want.year, got.year);
        check_field("out_month", want.month, got.month);
        check_field("out_day", want.day, got.day);
        check_field("weekday", want.wday, got.wday);
        check_field("month_length", want.mlen, got.mlen);
        check_field("first_weekday", want.first_wday, got.first_wday);
        check_field("range_clamped", want.clamped, got.clamped);
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("calendar_date_stepper_unit verification failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_saturation();
    test_home_clamping();
    test_leap_months();
    test_random_traffic(0, 0, 4, 60);
    test_random_traffic(75, 0, 4, 60);
    test_random_traffic(0, 75, 4, 60);
    test_random_traffic(31, 31, 4, 60);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("calendar_date_stepper_unit verification clean");
    end else begin
      $display("calendar_date_stepper_unit verification failed");
    end
    $finish;
  end

endmodule
